### rtl/core/hmvn_pkg.sv
package hmvn_pkg;

  // Widest grid side that the line store holds.
  localparam int unsigned SIDE_MAX = 256;

  // Field widths.
  localparam int HW    = 8;   // height pixel
  localparam int CRDW  = 8;   // row and column of a result beat
  localparam int CFGW  = 16;  // configuration write data
  localparam int SIDEW = 9;   // side length register
  localparam int IDXW  = 2;   // configuration register index
  localparam int OW    = 16;  // Q1.15 normal component

  // Datapath widths.
  localparam int XZW = 12;  // summed cross product x and z, at most +-1020
  localparam int MW  = 26;  // scaled component magnitude, at most 1020 * 65535
  localparam int QW  = 54;  // sum of three squared magnitudes
  localparam int AW  = 91;  // square-root search accumulators
  localparam int KW  = 16;  // rounded quotient before saturation
  localparam int JW  = 4;   // search step counter

  localparam logic [KW-1:0] K_SAT = 16'd32767;

  typedef enum logic [IDXW-1:0] {
    REG_SIDE    = 2'd0,
    REG_SPACING = 2'd1,
    REG_HSTEP   = 2'd2
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SQR,
    ST_SUM,
    ST_ITER,
    ST_DONE
  } norm_st_e;

  // One interior vertex handed from the line-store front end to the normalizer.
  typedef struct packed {
    logic [CRDW-1:0]       row;
    logic [CRDW-1:0]       col;
    logic signed [XZW-1:0] x;
    logic signed [XZW-1:0] z;
    logic                  last;
  } job_t;

endpackage

### rtl/core/heightmap_vertex_normal_generator.sv
// Heightmap vertex normal generator. Heightmap pixels enter one beat at a
// time in raster order; for every interior vertex a unit normal in Q1.15 is
// delivered with its row and column once the pixel below it has arrived.
// A pixel that completes no interior vertex is taken without waiting on the
// normalization unit. A pixel that completes one hands it to that unit,
// which takes one vertex at a time (handover, scale, square, sum, a 16-step
// rounded square-root division for all three components at once, then the
// output load); the next pixel that completes a vertex waits until the unit
// is idle again, and longer while the previous output beat is not taken.
// The two previous rows sit in one line-store memory with two read ports;
// after reset and after each configuration write the block prefetches from
// it before it accepts a pixel. The line store is not cleared after reset.
module heightmap_vertex_normal_generator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [hmvn_pkg::IDXW-1:0]         cfg_idx_i,
  input  logic [hmvn_pkg::CFGW-1:0]         cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [hmvn_pkg::HW-1:0]           height_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [hmvn_pkg::CRDW-1:0]         vertex_row_o,
  output logic [hmvn_pkg::CRDW-1:0]         vertex_col_o,
  output logic signed [hmvn_pkg::OW-1:0]    normal_x_o,
  output logic signed [hmvn_pkg::OW-1:0]    normal_y_o,
  output logic signed [hmvn_pkg::OW-1:0]    normal_z_o,
  output logic                              frame_last_o
);
  import hmvn_pkg::*;

  logic [SIDEW-1:0] side_q;
  logic [CFGW-1:0]  spacing_q, hstep_q;
  job_t             job;
  logic             job_valid, job_ready;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q    <= SIDEW'(256);
      spacing_q <= CFGW'(256);
      hstep_q   <= CFGW'(256);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SIDE:    side_q    <= cfg_data_i[SIDEW-1:0];
        REG_SPACING: spacing_q <= cfg_data_i;
        REG_HSTEP:   hstep_q   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  hmvn_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .side_i      (side_q),
    .cfg_we_i    (cfg_we_i),
    .height_i    (height_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .job_o       (job),
    .job_valid_o (job_valid),
    .job_ready_i (job_ready)
  );

  hmvn_norm u_norm (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .spacing_i    (spacing_q),
    .hstep_i      (hstep_q),
    .job_i        (job),
    .job_valid_i  (job_valid),
    .job_ready_o  (job_ready),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .vertex_row_o (vertex_row_o),
    .vertex_col_o (vertex_col_o),
    .normal_x_o   (normal_x_o),
    .normal_y_o   (normal_y_o),
    .normal_z_o   (normal_z_o),
    .frame_last_o (frame_last_o)
  );

endmodule

### rtl/core/hmvn_front.sv
module hmvn_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [hmvn_pkg::SIDEW-1:0]  side_i,
  input  logic                        cfg_we_i,
  input  logic [hmvn_pkg::HW-1:0]     height_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  output hmvn_pkg::job_t              job_o,
  output logic                        job_valid_o,
  input  logic                        job_ready_i
);
  import hmvn_pkg::*;

  localparam int CW = $clog2(SIDE_MAX);
  localparam int SW = $clog2(SIDE_MAX + 1);

  logic [2*HW-1:0] line_mem_q [SIDE_MAX];
  logic [2*HW-1:0] rd_a_q, rd_b_q;
  logic [CW-1:0]   col_q, row_q;
  logic [HW-1:0]   left_q, prev_ra_q;
  logic            data_ok_q;

  logic [15:0]   side_w;
  logic [SW-1:0] side_c;
  logic          col_wrap, col_end, row_end;
  logic [CW-1:0] col_e, row_e, col_nxt, row_nxt, addr_a, addr_b;
  logic [SW-1:0] row_t, col_n, row_n;
  logic          emit, in_acc;
  logic signed [XZW-1:0] dh_up, dh_left, dh_dleft, dh_down, dh_right, dh_uright;

  // Clamp the side length to the supported range.
  assign side_w = {7'd0, side_i};
  always_comb begin
    if (side_w > 16'(SIDE_MAX)) begin
      side_c = SW'(SIDE_MAX);
    end else if (side_w < 16'd3) begin
      side_c = SW'(3);
    end else begin
      side_c = SW'(side_w);
    end
  end

  // Position of the pixel in flight, wrapped against the current side.
  always_comb begin
    col_wrap = SW'(col_q) >= side_c;
    col_e    = col_wrap ? '0 : col_q;
    row_t    = SW'(row_q) + (col_wrap ? SW'(1) : SW'(0));
    row_e    = (row_t >= side_c) ? '0 : CW'(row_t);
    col_n    = SW'(col_e) + SW'(1);
    row_n    = SW'(row_e) + SW'(1);
    col_end  = col_n >= side_c;
    row_end  = row_n >= side_c;
    col_nxt  = col_end ? '0 : CW'(col_n);
    row_nxt  = col_end ? (row_end ? '0 : CW'(row_n)) : row_e;
  end

  // A vertex one row up is complete once the pixel below it arrives.
  assign emit = (row_e >= CW'(2)) && (col_e >= CW'(1))
             && ((SW+1)'(col_e) + (SW+1)'(2) <= (SW+1)'(side_c));

  assign in_ready_o  = data_ok_q && (!emit || job_ready_i);
  assign in_acc      = in_valid_i && in_ready_o;
  assign job_valid_o = in_valid_i && data_ok_q && emit;

  // Prefetch the line-store words for the next pixel and its right neighbor.
  assign addr_a = in_acc ? col_nxt : col_e;
  assign addr_b = addr_a + CW'(1);

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      line_mem_q[col_e] <= {rd_a_q[HW-1:0], height_i};
    end
    rd_a_q <= line_mem_q[addr_a];
    rd_b_q <= line_mem_q[addr_b];
  end

  // Neighbor heights of the vertex; the center cancels in both sums.
  always_comb begin
    dh_up     = XZW'(rd_a_q[2*HW-1:HW]);
    dh_left   = XZW'(prev_ra_q);
    dh_dleft  = XZW'(left_q);
    dh_down   = XZW'(height_i);
    dh_right  = XZW'(rd_b_q[HW-1:0]);
    dh_uright = XZW'(rd_b_q[2*HW-1:HW]);
    job_o.x   = dh_down + dh_uright + (dh_right <<< 1)
              - dh_up - dh_dleft - (dh_left <<< 1);
    job_o.z   = dh_dleft + dh_right + (dh_down <<< 1)
              - dh_left - dh_uright - (dh_up <<< 1);
    job_o.row = CRDW'(32'(row_e) - 32'd1);
    job_o.col = CRDW'(32'(col_e));
    job_o.last = ((SW+1)'(row_e) + (SW+1)'(1) == (SW+1)'(side_c))
              && ((SW+1)'(col_e) + (SW+1)'(2) == (SW+1)'(side_c));
  end

  // Counters and the left pixel.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      left_q    <= '0;
      data_ok_q <= 1'b0;
    end else begin
      data_ok_q <= !cfg_we_i;
      if (in_acc) begin
        col_q  <= col_nxt;
        row_q  <= row_nxt;
        left_q <= height_i;
      end
    end
  end

  // The word above the previous pixel is the left neighbor of the next vertex.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      prev_ra_q <= rd_a_q[HW-1:0];
    end
  end

endmodule

### rtl/core/hmvn_norm.sv
module hmvn_norm (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [hmvn_pkg::CFGW-1:0]         spacing_i,
  input  logic [hmvn_pkg::CFGW-1:0]         hstep_i,
  input  hmvn_pkg::job_t                    job_i,
  input  logic                              job_valid_i,
  output logic                              job_ready_o,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic [hmvn_pkg::CRDW-1:0]         vertex_row_o,
  output logic [hmvn_pkg::CRDW-1:0]         vertex_col_o,
  output logic signed [hmvn_pkg::OW-1:0]    normal_x_o,
  output logic signed [hmvn_pkg::OW-1:0]    normal_y_o,
  output logic signed [hmvn_pkg::OW-1:0]    normal_z_o,
  output logic                              frame_last_o
);
  import hmvn_pkg::*;

  norm_st_e st_q, st_d;
  job_t     job_q;
  logic [MW-1:0]   mag_q [3];
  logic [QW-1:0]   sq_q  [3];
  logic [QW-1:0]   q_q;
  logic [AW-1:0]   a_q [3], b_q [3], r_q [3];
  logic [KW-1:0]   k_q [3];
  logic [JW-1:0]   j_q;
  logic            out_valid_q, last_q;
  logic [CRDW-1:0] row_q, col_q;
  logic [OW-1:0]   nx_q, ny_q, nz_q;

  logic [CFGW-1:0] s_eff, h_eff;
  logic [XZW-1:0]  ax, az;
  logic [5:0]      sh_b, sh_q, sh_step;
  logic [AW-1:0]   cand [3];
  logic            take [3];
  logic [OW-1:0]   comp [3];
  logic [KW-1:0]   sat  [3];
  logic            job_acc, load_out;
  logic            neg [3];

  assign s_eff = (spacing_i == '0) ? CFGW'(1) : spacing_i;
  assign h_eff = (hstep_i == '0) ? CFGW'(1) : hstep_i;
  assign ax    = job_q.x[XZW-1] ? XZW'(-job_q.x) : XZW'(job_q.x);
  assign az    = job_q.z[XZW-1] ? XZW'(-job_q.z) : XZW'(job_q.z);
  assign neg[0] = job_q.x[XZW-1];
  assign neg[1] = 1'b0;
  assign neg[2] = job_q.z[XZW-1];

  // Next state.
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: if (job_valid_i) st_d = ST_MUL;
      ST_MUL:  st_d = ST_SQR;
      ST_SQR:  st_d = ST_SUM;
      ST_SUM:  st_d = ST_ITER;
      ST_ITER: if (j_q == '0) st_d = ST_DONE;
      ST_DONE: if (!out_valid_q || out_ready_i) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    job_ready_o = (st_q == ST_IDLE);
    load_out    = (st_q == ST_DONE) && (!out_valid_q || out_ready_i);
  end
  assign job_acc = job_valid_i && job_ready_o;

  // One search step: try the next lower bit of the rounded quotient k.
  // With T = 2k - 1, a tracks T*T*q and b tracks T*q.
  always_comb begin
    sh_b    = 6'(j_q) + 6'd2;
    sh_q    = {1'b0, j_q, 1'b0} + 6'd2;
    sh_step = 6'(j_q) + 6'd1;
    for (int l = 0; l < 3; l++) begin
      cand[l] = a_q[l] + (b_q[l] << sh_b) + (AW'(q_q) << sh_q);
      take[l] = cand[l] <= r_q[l];
      sat[l]  = (k_q[l] > K_SAT) ? K_SAT : k_q[l];
      comp[l] = neg[l] ? OW'(-sat[l]) : OW'(sat[l]);
    end
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    if (job_acc) begin
      job_q <= job_i;
    end
    unique case (st_q)
      ST_MUL: begin
        mag_q[0] <= MW'(ax) * MW'(h_eff);
        mag_q[1] <= MW'({s_eff, 2'b00}) + MW'({s_eff, 1'b0});
        mag_q[2] <= MW'(az) * MW'(h_eff);
      end
      ST_SQR: begin
        for (int l = 0; l < 3; l++) begin
          sq_q[l] <= QW'(mag_q[l]) * QW'(mag_q[l]);
        end
      end
      ST_SUM: begin
        q_q <= sq_q[0] + sq_q[1] + sq_q[2];
        for (int l = 0; l < 3; l++) begin
          a_q[l] <= AW'(sq_q[0] + sq_q[1] + sq_q[2]);
          b_q[l] <= AW'(0) - AW'(sq_q[0] + sq_q[1] + sq_q[2]);
          r_q[l] <= AW'(sq_q[l]) << 32;
          k_q[l] <= '0;
        end
        j_q <= JW'(KW - 1);
      end
      ST_ITER: begin
        for (int l = 0; l < 3; l++) begin
          if (take[l]) begin
            a_q[l] <= cand[l];
            b_q[l] <= b_q[l] + (AW'(q_q) << sh_step);
            k_q[l] <= k_q[l] | (KW'(1) << j_q);
          end
        end
        j_q <= j_q - JW'(1);
      end
      default: begin
      end
    endcase
    if (load_out) begin
      row_q  <= job_q.row;
      col_q  <= job_q.col;
      last_q <= job_q.last;
      nx_q   <= comp[0];
      ny_q   <= comp[1];
      nz_q   <= comp[2];
    end
  end

  // State and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign vertex_row_o = row_q;
  assign vertex_col_o = col_q;
  assign normal_x_o   = nx_q;
  assign normal_y_o   = ny_q;
  assign normal_z_o   = nz_q;
  assign frame_last_o = last_q;

`ifndef SYNTHESIS
  a_iter_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_ITER && j_q == '0) |=> (st_q == ST_DONE))
    else $error("search did not finish after its last step");
  a_sum_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_SUM) |=> (st_q == ST_ITER && j_q == JW'(KW - 1)))
    else $error("search did not start at the top bit");
  a_y_positive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !normal_y_o[OW-1])
    else $error("normal y component went negative");
`endif

endmodule

### bench/tb_heightmap_vertex_normal_generator.sv
`timescale 1ns / 1ps

module tb_heightmap_vertex_normal_generator;
  import hmvn_pkg::*;

  localparam logic [IDXW-1:0] REG_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [CRDW-1:0]      row;
    logic [CRDW-1:0]      col;
    logic signed [OW-1:0] nx;
    logic signed [OW-1:0] ny;
    logic signed [OW-1:0] nz;
    logic                 last;
  } vtx_normal_t;

  // One row of the directed table: a register write or a pixel, with an
  // optional hand-typed expected vertex.
  typedef struct {
    bit                is_cfg;
    logic [IDXW-1:0]   idx;
    logic [CFGW-1:0]   data;
    logic [HW-1:0]     h;
    bit                typed;
    vtx_normal_t       vtx;
  } dir_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [IDXW-1:0]      cfg_idx_i = '0;
  logic [CFGW-1:0]      cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [HW-1:0]        height_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [CRDW-1:0]      vertex_row_o;
  logic [CRDW-1:0]      vertex_col_o;
  logic signed [OW-1:0] normal_x_o;
  logic signed [OW-1:0] normal_y_o;
  logic signed [OW-1:0] normal_z_o;
  logic                 frame_last_o;

  heightmap_vertex_normal_generator dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the block's registers and line stores.
  logic [SIDEW-1:0] side_reg;
  logic [CFGW-1:0]  spacing_reg;
  logic [CFGW-1:0]  hstep_reg;
  logic [HW-1:0]    line_two_up [256];
  logic [HW-1:0]    line_one_up [256];
  logic [HW-1:0]    left_px;
  int unsigned      cur_row, cur_col;

  vtx_normal_t pending_normals[$];
  int          fail_count = 0;
  int          pixels_sent = 0;
  int          normals_checked = 0;
  int          idle_in_pct = 0;
  int          idle_out_pct = 0;
  bit          hold_req = 1'b0;

  // Rounded 32768 * c / sqrt(q), ties away from zero, saturated.
  function automatic logic signed [OW-1:0] unit_part(longint c, longint unsigned q);
    longint unsigned mag, t;
    logic [127:0]    lhs, rhs;
    int unsigned     lo, hi, k;
    mag = (c < 0) ? longint'(-c) : longint'(c);
    rhs = {64'd0, mag * mag} << 32;
    lo = 0;
    hi = 32768;
    while (lo < hi) begin
      k = (lo + hi + 1) / 2;
      t = 2 * longint'(k) - 1;
      lhs = 128'(t * t) * 128'(q);
      if (lhs <= rhs) lo = k;
      else hi = k - 1;
    end
    if (lo > 32767) lo = 32767;
    return (c < 0) ? -OW'(lo) : OW'(lo);
  endfunction

  // Advance the shadow by one pixel; returns 1 when a vertex completes.
  function automatic bit shade_pixel(input logic [HW-1:0] h, output vtx_normal_t v);
    int          di[6] = '{-1, 0, 1, 1, 0, -1};
    int          dj[6] = '{0, -1, -1, 0, 1, 1};
    int          dh[6];
    int unsigned side, r, c;
    int          centre, b;
    longint      sx, hx, xs, ys, zs, nx, ny, nz;
    longint unsigned q;
    bit          hit;
    side = side_reg;
    if (side < 3) side = 3;
    if (side > 256) side = 256;
    if (cur_col >= side) begin
      cur_col = 0;
      cur_row++;
    end
    if (cur_row >= side) cur_row = 0;
    r = cur_row;
    c = cur_col;
    hit = (r >= 2 && c >= 1 && c + 2 <= side);
    v = '0;
    if (hit) begin
      centre = line_one_up[c];
      dh[0] = int'(line_two_up[c]) - centre;
      dh[1] = int'(line_two_up[c-1]) - centre;
      dh[2] = int'(left_px) - centre;
      dh[3] = int'(h) - centre;
      dh[4] = int'(line_one_up[c+1]) - centre;
      dh[5] = int'(line_two_up[c+1]) - centre;
      xs = 0;
      ys = 0;
      zs = 0;
      for (int k = 0; k < 6; k++) begin
        b = (k + 1) % 6;
        xs += di[k] * dh[b] - dh[k] * di[b];
        ys += di[k] * dj[b] - dj[k] * di[b];
        zs += dh[k] * dj[b] - dj[k] * dh[b];
      end
      sx = (spacing_reg == 0) ? 1 : spacing_reg;
      hx = (hstep_reg == 0) ? 1 : hstep_reg;
      nx = hx * xs;
      ny = sx * ys;
      nz = hx * zs;
      q = nx * nx + ny * ny + nz * nz;
      v.row = CRDW'(r - 1);
      v.col = CRDW'(c);
      v.nx = unit_part(nx, q);
      v.ny = unit_part(ny, q);
      v.nz = unit_part(nz, q);
      v.last = (r + 1 == side && c + 2 == side);
    end
    line_two_up[c] = line_one_up[c];
    line_one_up[c] = h;
    left_px = h;
    cur_col = c + 1;
    if (cur_col >= side) begin
      cur_col = 0;
      cur_row = r + 1;
      if (cur_row >= side) cur_row = 0;
    end
    return hit;
  endfunction

  // Offer one pixel beat; a typed expectation replaces the predicted one.
  task automatic send_pixel(input logic [HW-1:0] h, input bit typed = 0,
                            input vtx_normal_t typed_vtx = '0);
    vtx_normal_t v;
    @(negedge clk_i);
    if ($urandom_range(99) < idle_in_pct) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    height_i = h;
    do @(posedge clk_i); while (!in_ready_o);
    pixels_sent++;
    if (shade_pixel(h, v)) pending_normals.push_back(typed ? typed_vtx : v);
  endtask

  // Register write once every pending normal is out and the block is quiet.
  task automatic write_reg(input logic [IDXW-1:0] idx, input logic [CFGW-1:0] data);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_normals.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = data;
    case (idx)
      REG_SIDE:    side_reg = data[SIDEW-1:0];
      REG_SPACING: spacing_reg = data;
      REG_HSTEP:   hstep_reg = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // One frame of the current side, drawn from one of several terrain styles.
  task automatic send_frame(input int unsigned side);
    int style, level;
    style = $urandom_range(3);
    level = $urandom_range(255);
    for (int i = 0; i < side * side; i++) begin
      case (style)
        0: level = $urandom_range(255);
        1: level = (level + int'($urandom_range(16)) - 8) & 8'hFF;
        2: level = $urandom_range(1) ? 255 : 0;
        default: if ($urandom_range(9) == 0) level = $urandom_range(255);
      endcase
      send_pixel(HW'(level));
    end
  endtask

  // Receiver: random stalls, plus a long hold-off when requested.
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_req = 1'b0;
      out_ready_i <= 1'b0;
      repeat (400) @(negedge clk_i);
    end else begin
      out_ready_i <= ($urandom_range(99) >= idle_out_pct);
    end
  end

  // Compare each delivered beat against the oldest expected normal.
  always @(posedge clk_i) begin
    vtx_normal_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_normals.size() == 0) begin
        $error("unexpected normal beat at row %0d col %0d", vertex_row_o, vertex_col_o);
        fail_count++;
      end else begin
        e = pending_normals.pop_front();
        normals_checked++;
        if (vertex_row_o !== e.row) begin
          $error("vertex_row: expected %0d, got %0d", e.row, vertex_row_o);
          fail_count++;
        end
        if (vertex_col_o !== e.col) begin
          $error("vertex_col: expected %0d, got %0d", e.col, vertex_col_o);
          fail_count++;
        end
        if (normal_x_o !== e.nx) begin
          $error("normal_x: expected %0d, got %0d", e.nx, normal_x_o);
          fail_count++;
        end
        if (normal_y_o !== e.ny) begin
          $error("normal_y: expected %0d, got %0d", e.ny, normal_y_o);
          fail_count++;
        end
        if (normal_z_o !== e.nz) begin
          $error("normal_z: expected %0d, got %0d", e.nz, normal_z_o);
          fail_count++;
        end
        if (frame_last_o !== e.last) begin
          $error("frame_last: expected %0d, got %0d", e.last, frame_last_o);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("** heightmap_vertex_normal_generator: FAILED **");
    $finish;
  end

  initial begin
    dir_row_t    dir_tbl[$];
    dir_row_t    row_e;
    vtx_normal_t flat_v;
    int unsigned side, phase;
    logic [CFGW-1:0] pick;

    side_reg = 9'd256;
    spacing_reg = 16'd256;
    hstep_reg = 16'd256;
    left_px = '0;
    cur_row = 0;
    cur_col = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings: two full rows of the widest grid and the start of a
    // third, then the side shrinks mid-row and the frame finishes at the
    // new size. The receiver idles more than the sender here.
    idle_in_pct = 27;
    idle_out_pct = 55;
    for (int i = 0; i < 2 * 256 + 6; i++) send_pixel(HW'($urandom_range(255)));
    write_reg(REG_SIDE, 16'd4);
    for (int i = 0; i < 4; i++) send_pixel(HW'($urandom_range(255)));

    // Directed table: clamped small side, flat frames, extreme heights,
    // zero and full-scale spacing and step, and an unused register index.
    // The sender idles more than the receiver from here on.
    idle_in_pct = 55;
    idle_out_pct = 27;
    flat_v = '{row: 8'd1, col: 8'd1, nx: 16'sd0, ny: 16'sd32767, nz: 16'sd0, last: 1'b1};
    row_e = '{is_cfg: 1, idx: REG_SIDE, data: 16'd0, h: 0, typed: 0, vtx: '0};
    dir_tbl.push_back(row_e);
    row_e.idx = REG_UNUSED;
    row_e.data = 16'hFFFF;
    dir_tbl.push_back(row_e);
    for (int i = 0; i < 9; i++) begin
      row_e = '{is_cfg: 0, idx: REG_SIDE, data: 0, h: 8'd255, typed: (i == 7), vtx: flat_v};
      dir_tbl.push_back(row_e);
    end
    for (int i = 0; i < 9; i++) begin
      row_e = '{is_cfg: 0, idx: REG_SIDE, data: 0, h: (i == 4) ? 8'd255 : 8'd0,
                typed: 0, vtx: '0};
      dir_tbl.push_back(row_e);
    end
    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].is_cfg) write_reg(dir_tbl[i].idx, dir_tbl[i].data);
      else send_pixel(dir_tbl[i].h, dir_tbl[i].typed, dir_tbl[i].vtx);
    end
    write_reg(REG_SPACING, 16'd0);
    write_reg(REG_HSTEP, 16'hFFFF);
    send_frame(3);
    write_reg(REG_SPACING, 16'hFFFF);
    write_reg(REG_HSTEP, 16'd0);
    send_frame(3);
    write_reg(REG_SIDE, 16'd2);
    write_reg(REG_SPACING, 16'd1);
    write_reg(REG_HSTEP, 16'd1);
    send_frame(3);

    // Oversized side acts as the widest grid: part of a row goes by without
    // wrapping, then the side shrinks mid-row and the frame finishes.
    write_reg(REG_SIDE, 16'd511);
    for (int i = 0; i < 6; i++) send_pixel(HW'($urandom_range(255)));
    write_reg(REG_SIDE, 16'd3);
    for (int i = 0; i < 6; i++) send_pixel(HW'($urandom_range(255)));

    // Neither side idles from here on. The receiver first holds off for a
    // long stretch while a frame full of vertices keeps arriving.
    idle_in_pct = 0;
    idle_out_pct = 0;
    write_reg(REG_SIDE, 16'd6);
    hold_req = 1'b1;
    send_frame(6);

    // Random phases of whole frames.
    phase = 0;
    while (pixels_sent < 650) begin
      side = ($urandom_range(7) == 0) ? $urandom_range(24, 13) : $urandom_range(12, 3);
      write_reg(REG_SIDE, CFGW'(side));
      for (int k = 0; k < 2; k++) begin
        case ($urandom_range(3))
          0: pick = 16'd1;
          1: pick = 16'hFFFF;
          2: pick = 16'd256;
          default: pick = CFGW'($urandom_range(65535));
        endcase
        write_reg(k ? REG_HSTEP : REG_SPACING, pick);
      end
      repeat ($urandom_range(2, 1)) send_frame(side);
      phase++;
    end

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_normals.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d pixels over %0d random phases; %0d vertex normals checked.",
             pixels_sent, phase, normals_checked);
    if (fail_count == 0) begin
      $display("** heightmap_vertex_normal_generator: PASSED **");
    end else begin
      $display("** heightmap_vertex_normal_generator: FAILED **");
    end
    $finish;
  end

endmodule
